### rtl/shdlc_pkg.sv
// Shared types and constants for the SHDLC frame unstuffer.
`default_nettype none
package shdlc_pkg;

    localparam int FRAME_MAX = 57;
    localparam int COUNT_W = 6;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT =
        (FRAME_MAX > 63) ? COUNT_W'(63) : COUNT_W'(FRAME_MAX);

    localparam logic [7:0] BYTE_DELIM      = 8'h7E;
    localparam logic [7:0] BYTE_ESC        = 8'h7D;
    localparam logic [7:0] ESC_CODE_DELIM  = 8'h5E;
    localparam logic [7:0] ESC_CODE_ESC    = 8'h5D;
    localparam logic [7:0] ESC_CODE_XON    = 8'h31;
    localparam logic [7:0] ESC_CODE_XOFF   = 8'h33;
    localparam logic [7:0] BYTE_XON        = 8'h11;
    localparam logic [7:0] BYTE_XOFF       = 8'h13;

    localparam logic       CFG_RX_ENABLE     = 1'b0;
    localparam logic       CFG_END_MIN_COUNT = 1'b1;
    localparam logic [COUNT_W-1:0] END_MIN_COUNT_RESET = 6'd40;

    typedef struct packed {
        logic               rx_enable;
        logic [COUNT_W-1:0] end_min_count;
    } shdlc_cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic               escape_pending;
    } shdlc_state_t;

    typedef struct packed {
        logic               stored_valid;
        logic [COUNT_W-1:0] stored_index;
        logic [7:0]         stored_byte;
        logic               frame_end;
        logic               overflow;
    } shdlc_result_t;

endpackage
`default_nettype wire

### rtl/shdlc_step.sv
// Per-byte decode: delimiter, escape and overflow decisions for one received byte.
`default_nettype none
module shdlc_step (
    input  wire logic [7:0]             rx_byte,
    input  wire shdlc_pkg::shdlc_cfg_t   cfg,
    input  wire shdlc_pkg::shdlc_state_t state_cur,
    output shdlc_pkg::shdlc_state_t      state_next,
    output shdlc_pkg::shdlc_result_t     result
);

    logic       emit;
    logic [7:0] emit_byte;

    always_comb
    begin
        state_next = state_cur;
        result     = '0;
        emit       = 1'b0;
        emit_byte  = '0;
        if (cfg.rx_enable)
        begin
            if (rx_byte == shdlc_pkg::BYTE_DELIM && state_cur.byte_count == '0)
            begin
                emit      = 1'b1;
                emit_byte = rx_byte;
            end
            else if (state_cur.byte_count != '0 && rx_byte != shdlc_pkg::BYTE_DELIM)
            begin
                if (state_cur.escape_pending)
                begin
                    unique case (rx_byte)
                        shdlc_pkg::ESC_CODE_DELIM:
                        begin
                            emit      = 1'b1;
                            emit_byte = shdlc_pkg::BYTE_DELIM;
                        end
                        shdlc_pkg::ESC_CODE_ESC:
                        begin
                            emit      = 1'b1;
                            emit_byte = shdlc_pkg::BYTE_ESC;
                        end
                        shdlc_pkg::ESC_CODE_XON:
                        begin
                            emit      = 1'b1;
                            emit_byte = shdlc_pkg::BYTE_XON;
                        end
                        shdlc_pkg::ESC_CODE_XOFF:
                        begin
                            emit      = 1'b1;
                            emit_byte = shdlc_pkg::BYTE_XOFF;
                        end
                        default:
                        begin
                            emit      = 1'b0;
                            emit_byte = '0;
                        end
                    endcase
                    state_next.escape_pending = 1'b0;
                    // drop an unknown escaped byte; still flag a full buffer
                    if (!emit && state_cur.byte_count >= shdlc_pkg::COUNT_LIMIT)
                    begin
                        state_next.byte_count = '0;
                        result.overflow       = 1'b1;
                    end
                end
                else if (rx_byte == shdlc_pkg::BYTE_ESC)
                begin
                    state_next.escape_pending = 1'b1;
                end
                else
                begin
                    emit      = 1'b1;
                    emit_byte = rx_byte;
                end
            end
            else if (rx_byte == shdlc_pkg::BYTE_DELIM &&
                     state_cur.byte_count > cfg.end_min_count)
            begin
                result.frame_end = 1'b1;
            end

            if (emit)
            begin
                if (state_cur.byte_count < shdlc_pkg::COUNT_LIMIT)
                begin
                    result.stored_valid   = 1'b1;
                    result.stored_index   = state_cur.byte_count;
                    result.stored_byte    = emit_byte;
                    state_next.byte_count = state_cur.byte_count + 6'd1;
                end
                else
                begin
                    state_next.byte_count     = '0;
                    state_next.escape_pending = 1'b0;
                    result.overflow           = 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/shdlc_frame_unstuffer.sv
// Top level of the SHDLC frame unstuffer: input register, byte decode, result register.
//
// Usage:
//   Received UART bytes enter on the s_axis request channel, one byte per request in
//   s_axis_tdata. Each accepted byte yields exactly one result request on m_axis:
//   m_axis_tdata carries the frame position and the unescaped byte, m_axis_tuser
//   flags a stored byte and a buffer overflow, m_axis_tlast marks the closing
//   delimiter of a long enough frame.
//   Path: an accepted byte is held in the input register and decoded into the result
//   register, from which its result is offered on m_axis.
//   Throughput: one byte per cycle while m_axis_tready stays high; the byte count and
//   escape flag update in the same cycle as the decode, which closes the state loop.
//   Stall: when m_axis_tready is low the result holds, one more byte waits in the
//   input register, and s_axis_tready drops only when both are full.
//   Reset: rst_n clears both stages, the byte count and escape flag; reception is
//   enabled and the end-of-frame minimum count is 40.
//   Configuration: write cfg_data to register cfg_index with cfg_we while idle;
//   index 0 is rx_enable, index 1 is end_min_count.
`default_nettype none
module shdlc_frame_unstuffer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [5:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [5:0] stored_index, [13:6] stored_byte, zero pad
    output logic [1:0]       m_axis_tuser,   // [0] stored_valid, [1] overflow
    output logic             m_axis_tlast    // frame_end
);

    shdlc_pkg::shdlc_cfg_t    cfg_reg;
    shdlc_pkg::shdlc_state_t  state_reg;
    shdlc_pkg::shdlc_state_t  state_next;
    shdlc_pkg::shdlc_result_t result_next;
    shdlc_pkg::shdlc_result_t result_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rx_enable     <= 1'b1;
            cfg_reg.end_min_count <= shdlc_pkg::END_MIN_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                shdlc_pkg::CFG_RX_ENABLE:     cfg_reg.rx_enable     <= cfg_data[0];
                shdlc_pkg::CFG_END_MIN_COUNT: cfg_reg.end_min_count <= cfg_data;
                default:                      cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    shdlc_step u_step (
        .rx_byte    (in_byte_reg),
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, result_reg.stored_byte, result_reg.stored_index};
    assign m_axis_tuser  = {result_reg.overflow, result_reg.stored_valid};
    assign m_axis_tlast  = result_reg.frame_end;

    a_store_excl_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("stored byte and overflow flagged together");

    a_store_excl_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tlast))
        else $error("stored byte and frame end flagged together");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[5:0] < shdlc_pkg::COUNT_LIMIT))
        else $error("stored index beyond buffer limit");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.byte_count <= shdlc_pkg::COUNT_LIMIT)
        else $error("byte count beyond buffer limit");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result_next.stored_valid) |=> (state_reg.byte_count == m_axis_tdata[5:0] + 6'd1))
        else $error("byte count did not follow stored index");

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the SHDLC frame unstuffer: directed and random requests.
`default_nettype none
module tb;

    typedef enum logic [1:0] {ROW_BYTE, ROW_SET_RX, ROW_SET_MIN} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [7:0]               val;
        logic                     typed;
        shdlc_pkg::shdlc_result_t res;
    } dir_row_t;

    localparam int HOLD_CYCLES = 80;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [5:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // predictor state and configuration
    logic [shdlc_pkg::COUNT_W-1:0] frame_count;
    logic                          esc_armed;
    logic                          rx_on;
    logic [shdlc_pkg::COUNT_W-1:0] end_min;

    shdlc_pkg::shdlc_result_t decoded_q[$];
    logic [7:0]               byte_q[$];
    dir_row_t                 dir_tab[$];
    int                       errors = 0;
    int                       send_idle_pct = 0;
    int                       recv_stall_pct = 0;
    logic                     hold_go = 1'b0;
    int                       stall_left = 0;

    shdlc_frame_unstuffer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic shdlc_pkg::shdlc_result_t unstuff_byte(input logic [7:0] b);
        shdlc_pkg::shdlc_result_t r;
        logic                     emit;
        logic [7:0]               ev;
        r = '0;
        emit = 1'b0;
        ev = '0;
        if (rx_on)
        begin
            if (b == shdlc_pkg::BYTE_DELIM && frame_count == 0)
            begin
                emit = 1'b1;
                ev = b;
            end
            else if (frame_count != 0 && b != shdlc_pkg::BYTE_DELIM)
            begin
                if (esc_armed)
                begin
                    case (b)
                        shdlc_pkg::ESC_CODE_DELIM:
                        begin
                            emit = 1'b1;
                            ev = shdlc_pkg::BYTE_DELIM;
                        end
                        shdlc_pkg::ESC_CODE_ESC:
                        begin
                            emit = 1'b1;
                            ev = shdlc_pkg::BYTE_ESC;
                        end
                        shdlc_pkg::ESC_CODE_XON:
                        begin
                            emit = 1'b1;
                            ev = shdlc_pkg::BYTE_XON;
                        end
                        shdlc_pkg::ESC_CODE_XOFF:
                        begin
                            emit = 1'b1;
                            ev = shdlc_pkg::BYTE_XOFF;
                        end
                        default:        emit = 1'b0;
                    endcase
                    esc_armed = 1'b0;
                    if (!emit && frame_count >= shdlc_pkg::COUNT_LIMIT)
                    begin
                        frame_count = '0;
                        r.overflow = 1'b1;
                    end
                end
                else if (b == shdlc_pkg::BYTE_ESC)
                    esc_armed = 1'b1;
                else
                begin
                    emit = 1'b1;
                    ev = b;
                end
            end
            else if (b == shdlc_pkg::BYTE_DELIM && frame_count > end_min)
                r.frame_end = 1'b1;

            if (emit)
            begin
                if (frame_count < shdlc_pkg::COUNT_LIMIT)
                begin
                    r.stored_valid = 1'b1;
                    r.stored_index = frame_count;
                    r.stored_byte = ev;
                    frame_count = frame_count + 1'b1;
                end
                else
                begin
                    frame_count = '0;
                    esc_armed = 1'b0;
                    r.overflow = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input shdlc_pkg::shdlc_result_t typed_res);
        shdlc_pkg::shdlc_result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = unstuff_byte(b);
        decoded_q.push_back(typed ? typed_res : r);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [5:0] data);
        drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == shdlc_pkg::CFG_RX_ENABLE)
            rx_on = data[0];
        else
            end_min = data;
    endtask

    task automatic queue_frame();
        int len;
        int pick;
        byte_q.push_back(shdlc_pkg::BYTE_DELIM);
        len = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 56) : $urandom_range(40, 62);
        repeat (len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                byte_q.push_back(shdlc_pkg::BYTE_ESC);
                case ($urandom_range(0, 3))
                    0: byte_q.push_back(shdlc_pkg::ESC_CODE_DELIM);
                    1: byte_q.push_back(shdlc_pkg::ESC_CODE_ESC);
                    2: byte_q.push_back(shdlc_pkg::ESC_CODE_XON);
                    default: byte_q.push_back(shdlc_pkg::ESC_CODE_XOFF);
                endcase
            end
            else if (pick < 14)
            begin
                byte_q.push_back(shdlc_pkg::BYTE_ESC);
                byte_q.push_back(8'($urandom_range(0, 255)));
            end
            else if (pick < 17)
                byte_q.push_back(shdlc_pkg::BYTE_DELIM);
            else
                byte_q.push_back(8'($urandom_range(0, 255)));
        end
        byte_q.push_back(shdlc_pkg::BYTE_DELIM);
        if ($urandom_range(0, 3) == 0)
            byte_q.push_back(shdlc_pkg::BYTE_DELIM);
    endtask

    task automatic run_phase(input int sidle, input int rstall, input logic en,
                             input logic [5:0] min_cnt, input int n, input logic pressure);
        write_reg(shdlc_pkg::CFG_RX_ENABLE, {5'd0, en});
        write_reg(shdlc_pkg::CFG_END_MIN_COUNT, min_cnt);
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        if (pressure)
        begin
            @(posedge clk);
            hold_go <= 1'b1;
            @(posedge clk);
            hold_go <= 1'b0;
        end
        repeat (n)
        begin
            if (byte_q.size() == 0)
            begin
                if ($urandom_range(0, 99) < 80)
                    queue_frame();
                else
                    repeat ($urandom_range(1, 6))
                        byte_q.push_back(8'($urandom_range(0, 255)));
            end
            send_byte(byte_q.pop_front(), 1'b0, '0);
        end
    endtask

    task automatic check_result();
        shdlc_pkg::shdlc_result_t want;
        shdlc_pkg::shdlc_result_t got;
        got.stored_valid = m_axis_tuser[0];
        got.overflow = m_axis_tuser[1];
        got.stored_index = m_axis_tdata[5:0];
        got.stored_byte = m_axis_tdata[13:6];
        got.frame_end = m_axis_tlast;
        if (decoded_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected request: tdata=%h tuser=%b tlast=%b",
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
        else
        begin
            want = decoded_q.pop_front();
            if (got !== want || m_axis_tdata[15:14] !== 2'b00)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp v=%b i=%0d b=%h end=%b ovf=%b, ",
                              "got v=%b i=%0d b=%h end=%b ovf=%b pad=%b"},
                             want.stored_valid, want.stored_index, want.stored_byte,
                             want.frame_end, want.overflow,
                             got.stored_valid, got.stored_index, got.stored_byte,
                             got.frame_end, got.overflow, m_axis_tdata[15:14]);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (hold_go)
            begin
                stall_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #5000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        frame_count = '0;
        esc_armed = 1'b0;
        rx_on = 1'b1;
        end_min = shdlc_pkg::END_MIN_COUNT_RESET;

        //                     kind         val    typed  {valid, index, byte, end, ovf}
        dir_tab.push_back({ROW_BYTE,    8'h00, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h7E, 1'b1, {1'b1, 6'd0, 8'h7E, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h7E, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'hFF, 1'b1, {1'b1, 6'd1, 8'hFF, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h00, 1'b1, {1'b1, 6'd2, 8'h00, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h7D, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h5E, 1'b1, {1'b1, 6'd3, 8'h7E, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h7D, 1'b0, 17'h0});
        dir_tab.push_back({ROW_BYTE,    8'h5D, 1'b1, {1'b1, 6'd4, 8'h7D, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h7D, 1'b0, 17'h0});
        dir_tab.push_back({ROW_BYTE,    8'h31, 1'b1, {1'b1, 6'd5, 8'h11, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h7D, 1'b0, 17'h0});
        dir_tab.push_back({ROW_BYTE,    8'h33, 1'b1, {1'b1, 6'd6, 8'h13, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h7D, 1'b0, 17'h0});
        dir_tab.push_back({ROW_BYTE,    8'hAA, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h7D, 1'b0, 17'h0});
        dir_tab.push_back({ROW_BYTE,    8'h7E, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h5E, 1'b1, {1'b1, 6'd7, 8'h7E, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_SET_MIN, 8'h00, 1'b0, 17'h0});
        dir_tab.push_back({ROW_BYTE,    8'h7E, 1'b1, {1'b0, 6'd0, 8'h00, 1'b1, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h7E, 1'b1, {1'b0, 6'd0, 8'h00, 1'b1, 1'b0}});
        dir_tab.push_back({ROW_SET_RX,  8'h00, 1'b0, 17'h0});
        dir_tab.push_back({ROW_BYTE,    8'h7E, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_BYTE,    8'h55, 1'b1, {1'b0, 6'd0, 8'h00, 1'b0, 1'b0}});
        dir_tab.push_back({ROW_SET_RX,  8'h01, 1'b0, 17'h0});
        dir_tab.push_back({ROW_BYTE,    8'h55, 1'b1, {1'b1, 6'd8, 8'h55, 1'b0, 1'b0}});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            case (dir_tab[i].kind)
                ROW_SET_RX:  write_reg(shdlc_pkg::CFG_RX_ENABLE, dir_tab[i].val[5:0]);
                ROW_SET_MIN: write_reg(shdlc_pkg::CFG_END_MIN_COUNT, dir_tab[i].val[5:0]);
                default:     send_byte(dir_tab[i].val, dir_tab[i].typed, dir_tab[i].res);
            endcase
        end

        //        sidle rstall en    min     n    pressure
        run_phase(0,  0,  1'b1, 6'd40, 120, 1'b0);
        run_phase(58, 0,  1'b1, 6'd0,  120, 1'b0);
        run_phase(0,  58, 1'b1, 6'd56, 120, 1'b1);
        run_phase(22, 22, 1'b1, 6'($urandom_range(0, 56)), 120, 1'b0);
        run_phase(0,  0,  1'b0, 6'd40, 20,  1'b0);
        run_phase(58, 0,  1'b1, 6'd23, 120, 1'b0);
        run_phase(0,  58, 1'b1, 6'd40, 120, 1'b1);
        run_phase(22, 22, 1'b1, 6'd0,  120, 1'b0);

        drain();
        repeat (4) @(posedge clk);
        errors += decoded_q.size();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
